[rtl/atpd_pkg.sv]
// shared types, constants and saturation helpers for the attitude pd torque block
package atpd_pkg;

	localparam int unsigned SQRT_ST = 32;
	localparam int unsigned SQRT_W  = 32;
	localparam int unsigned DIV_ST  = 31;
	localparam int unsigned TQ_W    = 48;

	localparam logic [31:0] PROP_GAIN_RST = 32'd429497;
	localparam logic [31:0] RATE_GAIN_RST = 32'd42949673;

	localparam logic [0:0] REG_PROP_GAIN = 1'b0;
	localparam logic [0:0] REG_RATE_GAIN = 1'b1;

	typedef logic signed [31:0] s32_t;
	localparam s32_t ONE_Q30 = 32'sd1073741824;

	// vec holds the target before the divider and the unit target after it
	typedef struct packed {
		s32_t        w;
		s32_t [2:0]  u;
		s32_t [2:0]  rate;
		s32_t [2:0]  vec;
		logic        deg;
	} sb_t;

	function automatic s32_t sat32(input logic signed [39:0] v);
		if (v > 40'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -40'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction

	function automatic logic signed [TQ_W-1:0] sat48(input logic signed [49:0] v);
		if (v > 50'sd140737488355327) begin
			return 48'sh7fffffffffff;
		end else if (v < -50'sd140737488355328) begin
			return 48'sh800000000000;
		end else begin
			return v[TQ_W-1:0];
		end
	endfunction

endpackage

[rtl/attitude_pd_torque_top.sv]
// pd attitude torque: target norm, division, rotations, error cross product, gains
// stages in order: squares and norm, sqrt, divide, rotate, cross product,
//   rotate back, gain and saturate
// throughput: one request per cycle; the 32-step root and 31-step quotient are
//   fully pipelined, the whole pipe holds while a result is stalled
// reset: all valid bits clear, gains return to 429497 and 42949673
module attitude_pd_torque_top import atpd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [0:0]             cfg_index,
	input  logic [31:0]            cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic signed [31:0]     quat_w,
	input  logic signed [31:0]     quat_x,
	input  logic signed [31:0]     quat_y,
	input  logic signed [31:0]     quat_z,
	input  logic signed [31:0]     rate_x,
	input  logic signed [31:0]     rate_y,
	input  logic signed [31:0]     rate_z,
	input  logic signed [31:0]     target_x,
	input  logic signed [31:0]     target_y,
	input  logic signed [31:0]     target_z,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [TQ_W-1:0] torque_x,
	output logic signed [TQ_W-1:0] torque_y,
	output logic signed [TQ_W-1:0] torque_z,
	output logic                   target_degenerate
);

	logic        en;
	logic [31:0] prop_gain_q, rate_gain_q;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q <= PROP_GAIN_RST;
			rate_gain_q <= RATE_GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROP_GAIN: prop_gain_q <= cfg_data;
				REG_RATE_GAIN: rate_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// squares and norm
	sb_t                sb_in, sb_s1, sb_s2;
	logic [2:0][63:0]   sq_s1;
	logic [63:0]        n2_s2;
	logic               vld_s1, vld_s2;

	assign sb_in.w    = quat_w;
	assign sb_in.u    = {quat_z, quat_y, quat_x};
	assign sb_in.rate = {rate_z, rate_y, rate_x};
	assign sb_in.vec  = {target_z, target_y, target_x};
	assign sb_in.deg  = (target_x == 32'sd0) && (target_y == 32'sd0) && (target_z == 32'sd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s1 <= sb_in;
			for (int i = 0; i < 3; i++) begin
				sq_s1[i] <= 64'($signed(sb_in.vec[i])) * 64'($signed(sb_in.vec[i]));
			end
			sb_s2 <= sb_s1;
			n2_s2 <= sq_s1[0] + sq_s1[1] + sq_s1[2];
		end
	end

	logic              sq_vld;
	logic [SQRT_W-1:0] root;
	sb_t               sb_sq;

	atpd_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (vld_s2),
		.rad     (n2_s2),
		.sb_in   (sb_s2),
		.vld_out (sq_vld),
		.root    (root),
		.sb_out  (sb_sq)
	);

	logic       dv_vld;
	s32_t [2:0] unit_t;
	sb_t        sb_dv, sb_r1in;

	atpd_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (sq_vld),
		.divisor (root),
		.sb_in   (sb_sq),
		.vld_out (dv_vld),
		.quot    (unit_t),
		.sb_out  (sb_dv)
	);

	always_comb begin
		sb_r1in     = sb_dv;
		sb_r1in.vec = unit_t;
	end

	// body x axis into the inertial frame
	logic signed [2:0][32:0] u_fwd, u_back;
	s32_t [2:0]              xaxis, act;
	logic                    r1_vld;
	sb_t                     sb_r1;

	for (genvar i = 0; i < 3; i++) begin : g_u
		assign u_fwd[i] = 33'($signed(sb_dv.u[i]));
	end
	assign xaxis = {32'sd0, 32'sd0, ONE_Q30};

	atpd_rot u_rot_fwd (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (dv_vld),
		.w       (sb_dv.w),
		.u       (u_fwd),
		.v       (xaxis),
		.sb_in   (sb_r1in),
		.vld_out (r1_vld),
		.r       (act),
		.sb_out  (sb_r1)
	);

	// inertial error axis = act x unit
	logic signed [2:0][63:0] cpa_s1, cpb_s1;
	s32_t [2:0]              erri_s2;
	logic                    cx_vld_s1, cx_vld_s2;
	sb_t                     cx_sb_s1, cx_sb_s2;

	for (genvar i = 0; i < 3; i++) begin : g_cx
		localparam int J = (i + 1) % 3;
		localparam int K = (i + 2) % 3;

		logic signed [39:0] e_n;
		assign e_n = 40'($signed(cpa_s1[i]) >>> 30) - 40'($signed(cpb_s1[i]) >>> 30);

		always_ff @(posedge clk) begin
			if (en) begin
				cpa_s1[i]  <= 64'($signed(act[J])) * 64'($signed(sb_r1.vec[K]));
				cpb_s1[i]  <= 64'($signed(act[K])) * 64'($signed(sb_r1.vec[J]));
				erri_s2[i] <= sat32(e_n);
			end
		end

		assign u_back[i] = 33'sd0 - 33'($signed(cx_sb_s2.u[i]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_vld_s1 <= 1'b0;
			cx_vld_s2 <= 1'b0;
		end else if (en) begin
			cx_vld_s1 <= r1_vld;
			cx_vld_s2 <= cx_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_sb_s1 <= sb_r1;
			cx_sb_s2 <= cx_sb_s1;
		end
	end

	// error axis back into the body frame by the conjugate
	s32_t [2:0] errb;
	logic       r2_vld;
	sb_t        sb_r2;

	atpd_rot u_rot_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (cx_vld_s2),
		.w       (cx_sb_s2.w),
		.u       (u_back),
		.v       (erri_s2),
		.sb_in   (cx_sb_s2),
		.vld_out (r2_vld),
		.r       (errb),
		.sb_out  (sb_r2)
	);

	// gains and saturation
	logic signed [2:0][42:0] p_s1;
	logic signed [2:0][48:0] d_s1;
	logic                    tq_vld_s1, deg_s1;

	for (genvar i = 0; i < 3; i++) begin : g_tq
		s32_t               e_use;
		logic signed [64:0] pp, dp;

		assign e_use = sb_r2.deg ? 32'sd0 : errb[i];
		assign pp    = 65'($signed({1'b0, prop_gain_q})) * 65'($signed(e_use));
		assign dp    = 65'($signed({1'b0, rate_gain_q})) * 65'($signed(sb_r2.rate[i]));

		always_ff @(posedge clk) begin
			if (en) begin
				p_s1[i] <= 43'(pp >>> 22);
				d_s1[i] <= 49'(dp >>> 16);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tq_vld_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			tq_vld_s1 <= r2_vld;
			out_valid <= tq_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			deg_s1            <= sb_r2.deg;
			torque_x          <= sat48(50'($signed(p_s1[0])) - 50'($signed(d_s1[0])));
			torque_y          <= sat48(50'($signed(p_s1[1])) - 50'($signed(d_s1[1])));
			torque_z          <= sat48(50'($signed(p_s1[2])) - 50'($signed(d_s1[2])));
			target_degenerate <= deg_s1;
		end
	end

	// a nonzero target never normalizes beyond one in magnitude
	assert property (@(posedge clk) disable iff (!arst_n)
		dv_vld && !sb_dv.deg |->
			($signed(unit_t[0]) <= ONE_Q30) && ($signed(unit_t[0]) >= -ONE_Q30) &&
			($signed(unit_t[1]) <= ONE_Q30) && ($signed(unit_t[1]) >= -ONE_Q30) &&
			($signed(unit_t[2]) <= ONE_Q30) && ($signed(unit_t[2]) >= -ONE_Q30))
		else $error("unit target out of range");

	// an accepted request enters the first stage
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld_s1)
		else $error("accepted request lost at entry");

	// a held pipe keeps its early stages frozen
	assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s1) && $stable(vld_s2) && $stable(n2_s2))
		else $error("pipe moved while output stalled");

endmodule

[rtl/atpd_sqrt.sv]
// pipelined integer square root, one result bit per stage
module atpd_sqrt import atpd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_in,
	input  logic [63:0]       rad,
	input  sb_t               sb_in,
	output logic              vld_out,
	output logic [SQRT_W-1:0] root,
	output sb_t               sb_out
);

	logic [63:0] rem_s  [SQRT_ST];
	logic [63:0] root_s [SQRT_ST];
	logic        vld_s  [SQRT_ST];
	sb_t         sb_s   [SQRT_ST];

	for (genvar k = 0; k < SQRT_ST; k++) begin : g_st
		logic [63:0] rem_i, root_i, bit_k, sum_k;
		logic        vld_i;
		sb_t         sb_i;

		if (k == 0) begin : g_first
			assign rem_i  = rad;
			assign root_i = '0;
			assign vld_i  = vld_in;
			assign sb_i   = sb_in;
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
			assign vld_i  = vld_s[k-1];
			assign sb_i   = sb_s[k-1];
		end

		assign bit_k = 64'd1 << (2 * (SQRT_ST - 1 - k));
		assign sum_k = root_i + bit_k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[k] <= sb_i;
				if (rem_i >= sum_k) begin
					rem_s[k]  <= rem_i - sum_k;
					root_s[k] <= (root_i >> 1) + bit_k;
				end else begin
					rem_s[k]  <= rem_i;
					root_s[k] <= root_i >> 1;
				end
			end
		end
	end

	assign vld_out = vld_s[SQRT_ST-1];
	assign root    = root_s[SQRT_ST-1][SQRT_W-1:0];
	assign sb_out  = sb_s[SQRT_ST-1];

endmodule

[rtl/atpd_div.sv]
// three-lane pipelined restoring divider, target * 2^30 / norm, truncated toward zero
module atpd_div import atpd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_in,
	input  logic [SQRT_W-1:0] divisor,
	input  sb_t               sb_in,
	output logic              vld_out,
	output s32_t [2:0]        quot,
	output sb_t               sb_out
);

	logic [2:0][62:0]       rem_s [DIV_ST];
	logic [2:0][DIV_ST-1:0] q_s   [DIV_ST];
	logic [2:0]             neg_s [DIV_ST];
	logic [SQRT_W-1:0]      dvs_s [DIV_ST];
	logic                   vld_s [DIV_ST];
	sb_t                    sb_s  [DIV_ST];

	for (genvar k = 0; k < DIV_ST; k++) begin : g_st
		logic [2:0][62:0]       rem_i;
		logic [2:0][DIV_ST-1:0] q_i;
		logic [2:0]             neg_i;
		logic [SQRT_W-1:0]      dvs_i;
		logic                   vld_i;
		sb_t                    sb_i;
		logic [62:0]            dsh;

		if (k == 0) begin : g_first
			for (genvar l = 0; l < 3; l++) begin : g_ln
				logic [31:0] tv, mag;
				assign tv       = sb_in.vec[l];
				assign mag      = tv[31] ? (32'd0 - tv) : tv;
				assign rem_i[l] = {1'b0, mag, 30'd0};
				assign neg_i[l] = tv[31];
				assign q_i[l]   = '0;
			end
			assign dvs_i = divisor;
			assign vld_i = vld_in;
			assign sb_i  = sb_in;
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign q_i   = q_s[k-1];
			assign neg_i = neg_s[k-1];
			assign dvs_i = dvs_s[k-1];
			assign vld_i = vld_s[k-1];
			assign sb_i  = sb_s[k-1];
		end

		assign dsh = 63'(dvs_i) << (DIV_ST - 1 - k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[k]  <= sb_i;
				dvs_s[k] <= dvs_i;
				neg_s[k] <= neg_i;
				for (int l = 0; l < 3; l++) begin
					if (rem_i[l] >= dsh) begin
						rem_s[k][l] <= rem_i[l] - dsh;
						q_s[k][l]   <= q_i[l] | (DIV_ST'(1) << (DIV_ST - 1 - k));
					end else begin
						rem_s[k][l] <= rem_i[l];
						q_s[k][l]   <= q_i[l];
					end
				end
			end
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_out
		logic [31:0] qe;
		assign qe      = {1'b0, q_s[DIV_ST-1][l]};
		assign quot[l] = neg_s[DIV_ST-1][l] ? $signed(32'd0 - qe) : $signed(qe);
	end

	assign vld_out = vld_s[DIV_ST-1];
	assign sb_out  = sb_s[DIV_ST-1];

endmodule

[rtl/atpd_rot.sv]
// four-stage quaternion rotation v' = v + 2w(u x v) + 2 u x (u x v), saturating
module atpd_rot import atpd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      vld_in,
	input  s32_t                      w,
	input  logic signed [2:0][32:0]   u,
	input  s32_t [2:0]                v,
	input  sb_t                       sb_in,
	output logic                      vld_out,
	output s32_t [2:0]                r,
	output sb_t                       sb_out
);

	logic signed [2:0][64:0] pa_s1, pb_s1;
	logic signed [2:0][32:0] u_s1, u_s2;
	s32_t [2:0]              v_s1, v_s2, v_s3;
	s32_t                    w_s1, w_s2;
	s32_t [2:0]              c_s2;
	logic signed [2:0][63:0] wc_s3;
	logic signed [2:0][64:0] da_s3, db_s3;
	s32_t [2:0]              r_s4;
	logic                    vld_s1, vld_s2, vld_s3, vld_s4;
	sb_t                     sb_s1, sb_s2, sb_s3, sb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_ln
		localparam int J = (i + 1) % 3;
		localparam int K = (i + 2) % 3;

		logic signed [39:0] c_n, r_n;

		// u x v, then u x c, each a floor shift by 30
		assign c_n = 40'($signed(pa_s1[i]) >>> 30) - 40'($signed(pb_s1[i]) >>> 30);
		assign r_n = 40'($signed(v_s3[i]))
			+ 40'(($signed(wc_s3[i]) >>> 30) <<< 1)
			+ ((40'($signed(da_s3[i]) >>> 30) - 40'($signed(db_s3[i]) >>> 30)) <<< 1);

		always_ff @(posedge clk) begin
			if (en) begin
				pa_s1[i] <= 65'($signed(u[J])) * 65'($signed(v[K]));
				pb_s1[i] <= 65'($signed(u[K])) * 65'($signed(v[J]));
				c_s2[i]  <= sat32(c_n);
				wc_s3[i] <= 64'($signed(w_s2)) * 64'($signed(c_s2[i]));
				da_s3[i] <= 65'($signed(u_s2[J])) * 65'($signed(c_s2[K]));
				db_s3[i] <= 65'($signed(u_s2[K])) * 65'($signed(c_s2[J]));
				r_s4[i]  <= sat32(r_n);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s1  <= w;
			u_s1  <= u;
			v_s1  <= v;
			sb_s1 <= sb_in;
			w_s2  <= w_s1;
			u_s2  <= u_s1;
			v_s2  <= v_s1;
			sb_s2 <= sb_s1;
			v_s3  <= v_s2;
			sb_s3 <= sb_s2;
			sb_s4 <= sb_s3;
		end
	end

	assign vld_out = vld_s4;
	assign r       = r_s4;
	assign sb_out  = sb_s4;

endmodule
